/* rtl/core/wavetable_oscillator_interp_macros.svh */
// ----------------------------------------------------------------------------
// wavetable_oscillator_interp_macros.svh
// assertion helpers shared by the oscillator modules, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef WAVETABLE_OSCILLATOR_INTERP_MACROS_SVH
`define WAVETABLE_OSCILLATOR_INTERP_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk, off during reset
`define WTOSC_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define WTOSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define WTOSC_ASSERT(label, ante, cons, msg)

`define WTOSC_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

/* rtl/core/wtosc_pkg.sv */
// ----------------------------------------------------------------------------
// wtosc_pkg
// shared widths, codes and item types of the wavetable oscillator
// ----------------------------------------------------------------------------
package wtosc_pkg;

  // parameter defaults
  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int FRAC_BITS_DEF   = 16;

  // fixed field widths
  localparam int IDX_W      = 10;
  localparam int SAMPLE_W   = 16;
  localparam int STEP_W     = 26;
  localparam int SIZE_W     = 11;
  localparam int OFS_W      = 27;
  localparam int GAIN_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 27;

  localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = SIZE_W'(1024);

  // items waiting between front and back
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TABLE_SIZE   = 2'd0,
    REG_PHASE_OFFSET = 2'd1,
    REG_GAIN         = 2'd2,
    REG_MOD_DEPTH    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    op_t                         op;
    logic [IDX_W-1:0]            entry_index;
    logic signed [SAMPLE_W-1:0]  entry_value;
    logic [STEP_W-1:0]           phase_step;
    logic signed [SAMPLE_W-1:0]  mod_in;
    logic signed [SAMPLE_W-1:0]  mix_in;
    logic                        block_last;
  } item_t;

  typedef struct packed {
    logic signed [OFS_W-1:0] phase_offset;
    logic [GAIN_W-1:0]       gain;
    logic [GAIN_W-1:0]       mod_depth;
  } cfg_t;

endpackage

/* rtl/core/wtosc_ram.sv */
// ----------------------------------------------------------------------------
// wtosc_ram
// generic one-write one-read ram with registered read data
// ----------------------------------------------------------------------------
module wtosc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

/* rtl/core/wtosc_front.sv */
// ----------------------------------------------------------------------------
// wtosc_front
// takes input items, drops out-of-range writes, queues the rest for the back
// ----------------------------------------------------------------------------
`include "wavetable_oscillator_interp_macros.svh"

module wtosc_front #(
  parameter int TABLE_DEPTH = wtosc_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic                                     in_req_type,
  input  logic [wtosc_pkg::IDX_W-1:0]              in_entry_index,
  input  logic signed [wtosc_pkg::SAMPLE_W-1:0]    in_entry_value,
  input  logic [wtosc_pkg::STEP_W-1:0]             in_phase_step,
  input  logic signed [wtosc_pkg::SAMPLE_W-1:0]    in_mod_in,
  input  logic signed [wtosc_pkg::SAMPLE_W-1:0]    in_mix_in,
  input  logic                                     in_block_last,
  output wtosc_pkg::item_t                         q_head,
  output logic                                     q_valid,
  input  logic                                     q_pop
);

  import wtosc_pkg::*;

  localparam int QAW = $clog2(QUEUE_DEPTH);

  item_t          q_r [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   count_r, count_nxt;

  item_t in_item;
  logic  keep_w;
  logic  push_w;
  logic  pop_w;

  assign in_item.op          = op_t'(in_req_type);
  assign in_item.entry_index = in_entry_index;
  assign in_item.entry_value = in_entry_value;
  assign in_item.phase_step  = in_phase_step;
  assign in_item.mod_in      = in_mod_in;
  assign in_item.mix_in      = in_mix_in;
  assign in_item.block_last  = in_block_last;

  // writes past the table are accepted and dropped here
  assign keep_w = (in_item.op == OP_SAMPLE) ||
                  (32'(in_entry_index) < 32'(TABLE_DEPTH));

  assign in_stall = (count_r == (QAW+1)'(QUEUE_DEPTH));
  assign push_w   = in_valid && !in_stall && keep_w;
  assign q_valid  = (count_r != '0);
  assign pop_w    = q_pop && q_valid;
  assign q_head   = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push_w ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop_w ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push_w && !pop_w) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_w && !push_w) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push_w) begin
      q_r[wr_ptr_r] <= in_item;
    end
  end

  `WTOSC_ASSERT_NEXT(a_fill_step, push_w && !pop_w, count_r == $past(count_r) + 1'b1, "queue count did not grow on push")
  `WTOSC_ASSERT(a_pop_nonempty, q_pop, count_r != '0, "back popped an empty queue")

endmodule

/* rtl/core/wtosc_back.sv */
// ----------------------------------------------------------------------------
// wtosc_back
// sequencer that runs table writes and sample items: phase wrap, two reads,
// interpolation, gain, ring modulation, mix and saturation
// ----------------------------------------------------------------------------
`include "wavetable_oscillator_interp_macros.svh"

module wtosc_back #(
  parameter int TABLE_DEPTH = wtosc_pkg::TABLE_DEPTH_DEF,
  parameter int FRAC_BITS   = wtosc_pkg::FRAC_BITS_DEF,
  localparam int SW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  wtosc_pkg::item_t                       q_head,
  input  logic                                   q_valid,
  output logic                                   q_pop,
  input  logic [SW-1:0]                          size,
  input  wtosc_pkg::cfg_t                        cfg,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [wtosc_pkg::SAMPLE_W-1:0]  out_sample,
  output logic                                   out_last
);

  import wtosc_pkg::*;

  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam int PW   = AW + FRAC_BITS;
  localparam int RSW  = ((PW > OFS_W) ? PW : OFS_W) + 2;
  localparam int RIW  = RSW - FRAC_BITS;
  localparam int DVW  = ((AW + 1) > (RIW - 1)) ? (AW + 1) : (RIW - 1);
  localparam int CNTW = $clog2(DVW);
  localparam int CMPW = ((STEP_W - FRAC_BITS) > SW) ? (STEP_W - FRAC_BITS) : SW;
  localparam int IPW  = FRAC_BITS + 18;
  localparam int MPW  = 35;
  localparam int GPW  = 33;
  localparam int FPW  = 37;

  localparam logic signed [IPW-1:0] IHALF = IPW'(1) << (FRAC_BITS - 1);
  localparam logic signed [MPW-1:0] MHALF = MPW'(16384);
  localparam logic signed [GPW-1:0] GHALF = GPW'(16384);
  localparam logic signed [FPW-1:0] FHALF = FPW'(16384);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STEP,
    ST_DIV,
    ST_POS,
    ST_IDX,
    ST_RDA,
    ST_RDB,
    ST_DIFF,
    ST_IPROD,
    ST_INTERP,
    ST_GAIN,
    ST_OSC,
    ST_FPROD,
    ST_FIN
  } state_t;

  state_t                     state_r, state_nxt;
  item_t                      item_r, item_nxt;
  logic [PW-1:0]              pos_r, pos_nxt;
  logic [DVW-1:0]             dvd_r, dvd_nxt;
  logic [SW-1:0]              rem_r, rem_nxt;
  logic [CNTW-1:0]            cnt_r, cnt_nxt;
  logic                       pass_r, pass_nxt;
  logic                       neg_r, neg_nxt;
  logic [FRAC_BITS-1:0]       frac_r, frac_nxt;
  logic [AW-1:0]              ia_r, ia_nxt;
  logic [AW-1:0]              ib_r, ib_nxt;
  logic signed [15:0]         a_r, a_nxt;
  logic signed [16:0]         diff_r, diff_nxt;
  logic signed [IPW-1:0]      iprod_r, iprod_nxt;
  logic signed [MPW-1:0]      mprod_r, mprod_nxt;
  logic signed [15:0]         interp_r, interp_nxt;
  logic signed [18:0]         factor_r, factor_nxt;
  logic signed [GPW-1:0]      gprod_r, gprod_nxt;
  logic signed [17:0]         osc_r, osc_nxt;
  logic signed [FPW-1:0]      fprod_r, fprod_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_sample_r, out_sample_nxt;
  logic                       out_last_r, out_last_nxt;

  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [SAMPLE_W-1:0]        ram_wdata;
  logic [AW-1:0]              ram_raddr;
  logic [SAMPLE_W-1:0]        ram_rdata;

  // step clamp and position add
  logic [SW-1:0]              size_m1;
  logic [CMPW-1:0]            step_int;
  logic [PW-1:0]              step_cl;
  logic [PW:0]                psum;

  // remainder unit, one dividend bit per cycle
  logic [SW:0]                div_cur;
  logic [SW:0]                div_sub;
  logic [SW-1:0]              div_rem;

  // read position
  logic [PW-1:0]              pos_new;
  logic signed [RSW-1:0]      rsum;
  logic [RIW-1:0]             rint;
  logic [RIW-1:0]             rmag;
  logic [SW-1:0]              idx_w;
  logic [SW-1:0]              nxt_w;

  // arithmetic
  logic signed [17:0]         mdiff;
  logic signed [IPW-1:0]      isum;
  logic signed [17:0]         interp_w;
  logic signed [MPW-1:0]      msum;
  logic signed [GPW-1:0]      gsum;
  logic signed [FPW-1:0]      fsum;
  logic signed [22:0]         res_w;
  logic signed [SAMPLE_W-1:0] sat_w;
  logic                       out_free;

  wtosc_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_waddr = AW'(q_head.entry_index);
  assign ram_wdata = q_head.entry_value;

  assign size_m1  = size - SW'(1);
  assign step_int = CMPW'(item_r.phase_step >> FRAC_BITS);
  assign step_cl  = (step_int >= CMPW'(size)) ? {size_m1[AW-1:0], {FRAC_BITS{1'b1}}}
                                              : PW'(item_r.phase_step);
  assign psum     = {1'b0, pos_r} + {1'b0, step_cl};

  assign div_cur  = {rem_r, dvd_r[DVW-1]};
  assign div_sub  = div_cur - {1'b0, size};
  assign div_rem  = (div_cur >= {1'b0, size}) ? div_sub[SW-1:0] : div_cur[SW-1:0];

  // floor modulo of a negative integer part: size - 1 - (~int mod size)
  assign pos_new  = {rem_r[AW-1:0], frac_r};
  assign rsum     = RSW'($signed({1'b0, pos_new})) + RSW'(cfg.phase_offset);
  assign rint     = rsum[RSW-1:FRAC_BITS];
  assign rmag     = rsum[RSW-1] ? ~rint : rint;
  assign idx_w    = neg_r ? (size_m1 - rem_r) : rem_r;
  assign nxt_w    = ((idx_w + SW'(1)) >= size) ? '0 : (idx_w + SW'(1));

  assign mdiff    = $signed({item_r.mod_in[15], item_r.mod_in[15], item_r.mod_in})
                    - 18'sd32768;
  assign isum     = (iprod_r + IHALF) >>> FRAC_BITS;
  assign interp_w = $signed(isum[17:0]) + $signed({{2{a_r[15]}}, a_r});
  assign msum     = (mprod_r + MHALF) >>> 15;
  assign gsum     = (gprod_r + GHALF) >>> 15;
  assign fsum     = (fprod_r + FHALF) >>> 15;
  assign res_w    = $signed(fsum[22:0])
                    + $signed({{7{item_r.mix_in[15]}}, item_r.mix_in});

  always_comb begin
    if (res_w > 23'sd32767) begin
      sat_w = 16'sh7fff;
    end else if (res_w < -23'sd32768) begin
      sat_w = 16'sh8000;
    end else begin
      sat_w = res_w[15:0];
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    pos_nxt        = pos_r;
    dvd_nxt        = dvd_r;
    rem_nxt        = rem_r;
    cnt_nxt        = cnt_r;
    pass_nxt       = pass_r;
    neg_nxt        = neg_r;
    frac_nxt       = frac_r;
    ia_nxt         = ia_r;
    ib_nxt         = ib_r;
    a_nxt          = a_r;
    diff_nxt       = diff_r;
    iprod_nxt      = iprod_r;
    mprod_nxt      = mprod_r;
    interp_nxt     = interp_r;
    factor_nxt     = factor_r;
    gprod_nxt      = gprod_r;
    osc_nxt        = osc_r;
    fprod_nxt      = fprod_r;
    out_valid_nxt  = out_valid_r;
    out_sample_nxt = out_sample_r;
    out_last_nxt   = out_last_r;
    q_pop          = 1'b0;
    ram_we         = 1'b0;
    ram_raddr      = ia_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_head.op == OP_WRITE) begin
            ram_we = 1'b1;
          end else begin
            item_nxt  = q_head;
            state_nxt = ST_STEP;
          end
        end
      end
      ST_STEP: begin
        dvd_nxt   = DVW'(psum[PW:FRAC_BITS]);
        frac_nxt  = psum[FRAC_BITS-1:0];
        rem_nxt   = '0;
        cnt_nxt   = '0;
        pass_nxt  = 1'b0;
        neg_nxt   = 1'b0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        rem_nxt = div_rem;
        dvd_nxt = dvd_r << 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNTW'(DVW - 1)) begin
          state_nxt = pass_r ? ST_IDX : ST_POS;
        end
      end
      ST_POS: begin
        pos_nxt   = pos_new;
        dvd_nxt   = DVW'(rmag[RIW-2:0]);
        frac_nxt  = rsum[FRAC_BITS-1:0];
        neg_nxt   = rsum[RSW-1];
        rem_nxt   = '0;
        cnt_nxt   = '0;
        pass_nxt  = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_IDX: begin
        ia_nxt    = idx_w[AW-1:0];
        ib_nxt    = nxt_w[AW-1:0];
        state_nxt = ST_RDA;
      end
      ST_RDA: begin
        ram_raddr = ia_r;
        state_nxt = ST_RDB;
      end
      ST_RDB: begin
        ram_raddr = ib_r;
        a_nxt     = ram_rdata;
        state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        diff_nxt  = $signed({ram_rdata[15], ram_rdata}) - $signed({a_r[15], a_r});
        state_nxt = ST_IPROD;
      end
      ST_IPROD: begin
        iprod_nxt = IPW'($signed({1'b0, frac_r})) * IPW'(diff_r);
        mprod_nxt = MPW'($signed({1'b0, cfg.mod_depth})) * MPW'(mdiff);
        state_nxt = ST_INTERP;
      end
      ST_INTERP: begin
        interp_nxt = interp_w[15:0];
        factor_nxt = $signed(msum[18:0]) + 19'sd32768;
        state_nxt  = ST_GAIN;
      end
      ST_GAIN: begin
        gprod_nxt = GPW'(interp_r) * GPW'($signed({1'b0, cfg.gain}));
        state_nxt = ST_OSC;
      end
      ST_OSC: begin
        osc_nxt   = gsum[17:0];
        state_nxt = ST_FPROD;
      end
      ST_FPROD: begin
        fprod_nxt = FPW'(osc_r) * FPW'(factor_r);
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = sat_w;
          out_last_nxt   = item_r.block_last;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
    end
    item_r       <= item_nxt;
    dvd_r        <= dvd_nxt;
    rem_r        <= rem_nxt;
    cnt_r        <= cnt_nxt;
    pass_r       <= pass_nxt;
    neg_r        <= neg_nxt;
    frac_r       <= frac_nxt;
    ia_r         <= ia_nxt;
    ib_r         <= ib_nxt;
    a_r          <= a_nxt;
    diff_r       <= diff_nxt;
    iprod_r      <= iprod_nxt;
    mprod_r      <= mprod_nxt;
    interp_r     <= interp_nxt;
    factor_r     <= factor_nxt;
    gprod_r      <= gprod_nxt;
    osc_r        <= osc_nxt;
    fprod_r      <= fprod_nxt;
    out_sample_r <= out_sample_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_last   = out_last_r;

  `WTOSC_ASSERT_NEXT(a_fin_hold, state_r == ST_FIN && out_valid_r && out_stall, state_r == ST_FIN && out_valid_r, "result overwritten while stalled")
  `WTOSC_ASSERT(a_read_range, state_r == ST_RDA, (SW'(ia_r) < size) && (SW'(ib_r) < size), "read index beyond table size in use")

endmodule

/* rtl/core/wavetable_oscillator_interp.sv */
// ----------------------------------------------------------------------------
// wavetable_oscillator_interp
// wavetable oscillator with linear interpolation, gain, ring modulation
// and saturating mix into an incoming sample stream
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake            moves
//   in_*      input      in_valid / in_stall  table write item or sample item
//   out_*     output     out_valid/out_stall  one mixed sample per sample item
//   cfg_*     input      cfg_valid/cfg_ready  register index and write data
//
// a write item goes into the table as it leaves the queue; a sample item's
// time is set by the bit-serial remainder unit that wraps the position and
// then the read position, and by the two table reads through the single ram
// read port. the back takes no new item until it is done with the last.
// reset is synchronous: position and registers return to defaults, the queue
// empties; table contents stay undefined until written.
// a four-item queue keeps the input side moving while the back is busy, and
// the result register holds its item while out_stall is high.
// ----------------------------------------------------------------------------
module wavetable_oscillator_interp #(
  parameter int TABLE_DEPTH = wtosc_pkg::TABLE_DEPTH_DEF,
  parameter int FRAC_BITS   = wtosc_pkg::FRAC_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // input items
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic                                    in_req_type,
  input  logic [wtosc_pkg::IDX_W-1:0]             in_entry_index,
  input  logic signed [wtosc_pkg::SAMPLE_W-1:0]   in_entry_value,
  input  logic [wtosc_pkg::STEP_W-1:0]            in_phase_step,
  input  logic signed [wtosc_pkg::SAMPLE_W-1:0]   in_mod_in,
  input  logic signed [wtosc_pkg::SAMPLE_W-1:0]   in_mix_in,
  input  logic                                    in_block_last,
  // result items
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [wtosc_pkg::SAMPLE_W-1:0]   out_sample_out,
  output logic                                    out_last_of_block,
  // register writes
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [wtosc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [wtosc_pkg::CFG_DATA_W-1:0]        cfg_data
);

  import wtosc_pkg::*;

  localparam int SW = $clog2(TABLE_DEPTH + 1);
  localparam int CW = (SIZE_W > SW) ? SIZE_W : SW;

  // configuration registers
  logic [SIZE_W-1:0]       table_size_r, table_size_nxt;
  logic signed [OFS_W-1:0] phase_offset_r, phase_offset_nxt;
  logic [GAIN_W-1:0]       gain_r, gain_nxt;
  logic [GAIN_W-1:0]       mod_depth_r, mod_depth_nxt;

  logic                    cfg_we;
  logic [CW-1:0]           ts_w;
  logic [SW-1:0]           size_w;
  cfg_t                    cfg_w;

  item_t                   q_head;
  logic                    q_valid;
  logic                    q_pop;

  // the user must write registers only while no item is in flight; the block does not enforce it, so always ready
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_comb begin
    table_size_nxt   = table_size_r;
    phase_offset_nxt = phase_offset_r;
    gain_nxt         = gain_r;
    mod_depth_nxt    = mod_depth_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TABLE_SIZE:   table_size_nxt   = cfg_data[SIZE_W-1:0];
        REG_PHASE_OFFSET: phase_offset_nxt = $signed(cfg_data[OFS_W-1:0]);
        REG_GAIN:         gain_nxt         = cfg_data[GAIN_W-1:0];
        REG_MOD_DEPTH:    mod_depth_nxt    = cfg_data[GAIN_W-1:0];
        default: begin
          table_size_nxt = table_size_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r   <= TABLE_SIZE_RST;
      phase_offset_r <= '0;
      gain_r         <= '0;
      mod_depth_r    <= '0;
    end else begin
      table_size_r   <= table_size_nxt;
      phase_offset_r <= phase_offset_nxt;
      gain_r         <= gain_nxt;
      mod_depth_r    <= mod_depth_nxt;
    end
  end

  // size in use: table_size clamped to two entries and the table depth
  assign ts_w = CW'(table_size_r);

  always_comb begin
    if (ts_w < CW'(2)) begin
      size_w = SW'(2);
    end else if (ts_w > CW'(TABLE_DEPTH)) begin
      size_w = SW'(TABLE_DEPTH);
    end else begin
      size_w = SW'(ts_w);
    end
  end

  assign cfg_w.phase_offset = phase_offset_r;
  assign cfg_w.gain         = gain_r;
  assign cfg_w.mod_depth    = mod_depth_r;

  // front: accept, drop writes past the table, queue
  wtosc_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_entry_index (in_entry_index),
    .in_entry_value (in_entry_value),
    .in_phase_step  (in_phase_step),
    .in_mod_in      (in_mod_in),
    .in_mix_in      (in_mix_in),
    .in_block_last  (in_block_last),
    .q_head         (q_head),
    .q_valid        (q_valid),
    .q_pop          (q_pop)
  );

  // back: table writes, phase wrap, interpolation and mix, result register
  wtosc_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_head     (q_head),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .size       (size_w),
    .cfg        (cfg_w),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_sample (out_sample_out),
    .out_last   (out_last_of_block)
  );

endmodule

/* test/tb_wavetable_oscillator_interp.sv */
// ----------------------------------------------------------------------------
// tb_wavetable_oscillator_interp
// self-checking bench for the wavetable oscillator: drives table write and
// sample items with random gaps and back-pressure, predicts every mixed sample
// in a scoreboard class and compares results in order, field by field
// ----------------------------------------------------------------------------
module tb_wavetable_oscillator_interp;
  timeunit 1ns;
  timeprecision 1ps;

  import wtosc_pkg::*;

  localparam int TABLE_DEPTH  = TABLE_DEPTH_DEF;
  localparam int FRAC         = FRAC_BITS_DEF;
  // settling margin for the slowest sample item plus the four the queue holds
  localparam int SETTLE_CYCLES = 200;
  localparam int RAND_PHASES   = 14;
  localparam int PHASE_ITEMS   = 19;
  localparam longint TIMEOUT_NS = 64'd6_000_000;

  // one expected result item
  typedef struct {
    logic signed [SAMPLE_W-1:0] level;
    logic                       last_flag;
  } osc_result_t;

  // --------------------------------------------------------------------------
  // scoreboard: own copy of table, position and registers, expected samples
  // --------------------------------------------------------------------------
  class osc_scoreboard;
    logic signed [SAMPLE_W-1:0] wave [TABLE_DEPTH];
    longint                     size_reg;
    longint                     offset_reg;
    longint                     gain_reg;
    longint                     depth_reg;
    longint                     position;
    osc_result_t                pending_samples [$];
    int                         errors;

    function new();
      size_reg   = 1024;
      offset_reg = 0;
      gain_reg   = 0;
      depth_reg  = 0;
      position   = 0;
      errors     = 0;
      foreach (wave[i]) wave[i] = '0;
    endfunction

    // round half up: add half, then floor shift
    function longint round_q(longint x, int s);
      return (x + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function int pending();
      return pending_samples.size();
    endfunction

    // register write seen on the cfg channel
    function void note_cfg(cfg_reg_t r, logic [CFG_DATA_W-1:0] d);
      case (r)
        REG_TABLE_SIZE:   size_reg   = longint'(d[SIZE_W-1:0]);
        REG_PHASE_OFFSET: offset_reg = {{(64-OFS_W){d[OFS_W-1]}}, d[OFS_W-1:0]};
        REG_GAIN:         gain_reg   = longint'(d[GAIN_W-1:0]);
        REG_MOD_DEPTH:    depth_reg  = longint'(d[GAIN_W-1:0]);
        default: ;
      endcase
    endfunction

    // accepted input item: table write, or predict one mixed sample
    function void take_item(item_t it);
      longint sz, lim, step, rd, idx, nxt, frac, a, b;
      longint interp, osc, factor, modv, mixv, res;
      osc_result_t want;
      if (it.op == OP_WRITE) begin
        wave[it.entry_index] = it.entry_value;
        return;
      end
      sz = size_reg;
      if (sz < 2) sz = 2;
      if (sz > TABLE_DEPTH) sz = TABLE_DEPTH;
      lim  = sz << FRAC;
      step = longint'(it.phase_step);
      if (step > lim - 1) step = lim - 1;
      position = (position + step) % lim;
      // read position wraps both ways
      rd = (position + offset_reg) % lim;
      if (rd < 0) rd += lim;
      idx  = rd >> FRAC;
      frac = rd & ((longint'(1) << FRAC) - 1);
      nxt  = idx + 1;
      if (nxt >= sz) nxt = 0;
      a = wave[idx];
      b = wave[nxt];
      interp = round_q(a * (longint'(1) << FRAC) + frac * (b - a), FRAC);
      osc    = round_q(interp * gain_reg, 15);
      modv   = it.mod_in;
      mixv   = it.mix_in;
      factor = 32768 + round_q(depth_reg * (modv - 32768), 15);
      res    = mixv + round_q(osc * factor, 15);
      if (res > 32767) res = 32767;
      if (res < -32768) res = -32768;
      want.level     = res[SAMPLE_W-1:0];
      want.last_flag = it.block_last;
      pending_samples.push_back(want);
    endfunction

    function void fail_note(string what, osc_result_t want,
                            logic signed [SAMPLE_W-1:0] lvl, logic lst);
      errors++;
      if (errors <= 10)
        $display("%0t %s: expected %0d last %0b, got %0d last %0b",
                 $time, what, want.level, want.last_flag, lvl, lst);
    endfunction

    // accepted result item against the oldest expectation
    function void check_sample(logic signed [SAMPLE_W-1:0] lvl, logic lst);
      osc_result_t want;
      if (pending_samples.size() == 0) begin
        want.level     = '0;
        want.last_flag = 1'b0;
        fail_note("result with nothing pending", want, lvl, lst);
        return;
      end
      want = pending_samples.pop_front();
      if (lvl !== want.level || lst !== want.last_flag)
        fail_note("sample mismatch", want, lvl, lst);
    endfunction

    function void close_out();
      while (pending_samples.size() != 0)
        fail_note("missing result", pending_samples.pop_front(), 'x, 1'bx);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // block ports
  // --------------------------------------------------------------------------
  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic                       in_req_type;
  logic [IDX_W-1:0]           in_entry_index;
  logic signed [SAMPLE_W-1:0] in_entry_value;
  logic [STEP_W-1:0]          in_phase_step;
  logic signed [SAMPLE_W-1:0] in_mod_in;
  logic signed [SAMPLE_W-1:0] in_mix_in;
  logic                       in_block_last;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [SAMPLE_W-1:0] out_sample_out;
  logic                       out_last_of_block;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_data;

  wavetable_oscillator_interp DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_entry_index    (in_entry_index),
    .in_entry_value    (in_entry_value),
    .in_phase_step     (in_phase_step),
    .in_mod_in         (in_mod_in),
    .in_mix_in         (in_mix_in),
    .in_block_last     (in_block_last),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_sample_out    (out_sample_out),
    .out_last_of_block (out_last_of_block),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  osc_scoreboard sb = new();

  // entries written so far; a sample never reads an unwritten entry
  bit          written [TABLE_DEPTH];
  // size in use after clamping, as the next samples will see it
  int unsigned cur_size = 1024;
  // phases with no idling on either side
  bit          calm = 1'b0;

  // 4 ns clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #(TIMEOUT_NS);
    $display("end of test: mismatches");
    $finish;
  end

  // --------------------------------------------------------------------------
  // random helpers
  // --------------------------------------------------------------------------
  function automatic int unsigned idle_cycles();
    return calm ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic int unsigned clamp_size(int unsigned s);
    if (s < 2) return 2;
    if (s > TABLE_DEPTH) return TABLE_DEPTH;
    return s;
  endfunction

  // signed sample with its extremes weighted up
  function automatic logic signed [SAMPLE_W-1:0] rand_s16();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_q15(int unsigned sel);
    case (sel)
      0: return 16'h0000;
      1: return 16'h8000;
      2: return 16'hFFFF;
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  function automatic logic [OFS_W-1:0] pick_offset(int unsigned sel, int unsigned csz);
    case (sel)
      0: return OFS_W'(-33554432);
      1: return OFS_W'(33554432);
      2: return '0;
      3: return OFS_W'($urandom);
      default: return OFS_W'(int'($urandom_range(0, 6 * csz * 65536))
                             - 3 * int'(csz) * 65536);
    endcase
  endfunction

  // all fields random, including the ones the op ignores
  function automatic item_t random_fields();
    item_t it;
    it.op          = op_t'($urandom_range(0, 1));
    it.entry_index = IDX_W'($urandom);
    it.entry_value = SAMPLE_W'($urandom);
    it.phase_step  = STEP_W'($urandom);
    it.mod_in      = SAMPLE_W'($urandom);
    it.mix_in      = SAMPLE_W'($urandom);
    it.block_last  = 1'($urandom);
    return it;
  endfunction

  function automatic item_t random_sample();
    item_t it;
    it    = random_fields();
    it.op = OP_SAMPLE;
    case ($urandom_range(0, 9))
      0:       it.phase_step = '0;
      1:       it.phase_step = '1;
      2, 3:    it.phase_step = STEP_W'($urandom);
      4, 5:    it.phase_step = STEP_W'($urandom_range(0, cur_size * 65536 - 1));
      default: it.phase_step = STEP_W'($urandom_range(0, 4 * 65536));
    endcase
    it.mod_in     = rand_s16();
    it.mix_in     = rand_s16();
    it.block_last = ($urandom_range(0, 3) == 0);
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------
  // one input item: random gap, then hold valid until accepted
  task automatic send_item(input item_t it);
    int unsigned gap;
    gap = idle_cycles();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= it.op;
    in_entry_index <= it.entry_index;
    in_entry_value <= it.entry_value;
    in_phase_step  <= it.phase_step;
    in_mod_in      <= it.mod_in;
    in_mix_in      <= it.mix_in;
    in_block_last  <= it.block_last;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (it.op == OP_WRITE) written[it.entry_index] = 1'b1;
    sb.take_item(it);
  endtask

  task automatic sample_now(logic [STEP_W-1:0] step, logic signed [SAMPLE_W-1:0] modv,
                            logic signed [SAMPLE_W-1:0] mixv, logic lst);
    item_t it;
    it            = random_fields();
    it.op         = OP_SAMPLE;
    it.phase_step = step;
    it.mod_in     = modv;
    it.mix_in     = mixv;
    it.block_last = lst;
    send_item(it);
  endtask

  // sender holds off until every expected sample is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // valid stays high across back-to-back register writes
  task automatic write_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= d;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.note_cfg(r, d);
  endtask

  // all four registers, only once the block has gone quiet; the unused
  // upper data bits carry noise that the block has to mask
  task automatic configure(logic [SIZE_W-1:0] size, logic [OFS_W-1:0] ofs,
                           logic [GAIN_W-1:0] g, logic [GAIN_W-1:0] dep);
    drain();
    // write items may still be in the back with no result to wait for
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_TABLE_SIZE, {16'($urandom), size});
    write_reg(REG_PHASE_OFFSET, ofs);
    write_reg(REG_GAIN, {11'($urandom), g});
    write_reg(REG_MOD_DEPTH, {11'($urandom), dep});
    cfg_valid <= 1'b0;
    cur_size = clamp_size(size);
  endtask

  // write every entry below upto that has not been written yet
  task automatic fill_table(int unsigned upto);
    item_t it;
    for (int i = 0; i < upto; i++) begin
      if (!written[i]) begin
        it             = random_fields();
        it.op          = OP_WRITE;
        it.entry_index = IDX_W'(i);
        case (i)
          0: it.entry_value = 16'sh7FFF;
          1: it.entry_value = 16'sh8000;
          2: it.entry_value = 16'sh0000;
          3: it.entry_value = 16'sh0001;
          4: it.entry_value = 16'shFFFF;
          default: it.entry_value = rand_s16();
        endcase
        send_item(it);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // result side: random stall per item, then wait for valid
  // --------------------------------------------------------------------------
  initial begin
    int unsigned hold;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      hold = idle_cycles();
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      sb.check_sample(out_sample_out, out_last_of_block);
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned size_plan [9] = '{0, 1, 3, 100, 1024, 2047, 1025, 7, 512};
    int unsigned sz;
    int unsigned csz;
    int unsigned sel;
    item_t       it;

    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_req_type    <= OP_WRITE;
    in_entry_index <= '0;
    in_entry_value <= '0;
    in_phase_step  <= '0;
    in_mod_in      <= '0;
    in_mix_in      <= '0;
    in_block_last  <= 1'b0;
    cfg_valid      <= 1'b0;
    cfg_index      <= REG_TABLE_SIZE;
    cfg_data       <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: small table with corner entries, unity gain, no modulation
    configure(11'd16, '0, 16'h8000, 16'h0000);
    fill_table(16);
    sample_now(26'h0000000, 16'sh0000, 16'sh0000, 1'b0);  // entry 0 exactly
    sample_now(26'h0008000, 16'sh7FFF, 16'sh0000, 1'b1);  // halfway between 0 and 1
    sample_now(26'h0008000, 16'sh8000, 16'sh8000, 1'b0);  // saturates low
    sample_now(26'h00E0000, 16'sh0000, 16'sh0000, 1'b1);  // last entry
    sample_now(26'h0008000, 16'sh0000, 16'sh7FFF, 1'b0);  // next index wraps to 0
    sample_now(26'h3FFFFFF, 16'sh0000, 16'sh7FFF, 1'b1);  // step clamped below size
    // smallest table, most negative in-range offset, full gain and depth;
    // the old position lies beyond the new size and wraps in
    configure(11'd2, OFS_W'(-33554432), 16'hFFFF, 16'h8000);
    sample_now(26'h0000000, 16'sh8000, 16'sh0000, 1'b0);
    sample_now(26'h0010000, 16'sh7FFF, 16'sh8000, 1'b1);
    sample_now(26'h3FFFFFF, 16'sh0000, 16'sh7FFF, 1'b0);
    sample_now(26'h0001234, 16'sh4000, 16'sh0000, 1'b1);
    // size below range clamps to two, zero gain, depth above unity
    configure(11'd1, OFS_W'(33554432), 16'h0000, 16'hFFFF);
    sample_now(26'h0018000, 16'sh8000, 16'sh7FFF, 1'b0);
    sample_now(26'h3FFFFFF, 16'sh7FFF, 16'sh8000, 1'b1);
    // zero size, most negative offset the field holds
    configure(11'd0, {1'b1, {(OFS_W-1){1'b0}}}, 16'h8000, 16'h4000);
    sample_now(26'h000C000, 16'sh0000, 16'sh4000, 1'b0);
    sample_now(26'h0020000, 16'shC000, 16'shC000, 1'b1);

    // random phases: new settings each time, table grown before it is read
    for (int p = 0; p < RAND_PHASES; p++) begin
      sz  = (p < 9) ? size_plan[p] : $urandom_range(0, 2047);
      csz = clamp_size(sz);
      sel = (p < 8) ? p % 4 : $urandom_range(0, 4);
      configure(SIZE_W'(sz), pick_offset(sel, csz), pick_q15(sel),
                pick_q15((p < 8) ? (p + 2) % 4 : $urandom_range(0, 3)));
      fill_table(csz);
      calm = ($urandom_range(0, 4) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 3) == 0) begin
          // rewrite any entry; written entries only ever stay written
          it             = random_fields();
          it.op          = OP_WRITE;
          it.entry_value = rand_s16();
          send_item(it);
        end else begin
          send_item(random_sample());
        end
        // now and then the sender waits for the pipe to empty mid-phase
        if ($urandom_range(0, 149) == 0 || (p == 2 && n == 10))
          drain();
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    sb.close_out();
    if (sb.errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
